FILE: rtl/sct_pkg.sv
// Shared types and constants for the step cadence tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package sct_pkg;

  localparam int WINDOW_DEPTH = 8;
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W        = SLOT_W + 2;

  localparam int DATA_W = 32;
  localparam int Q_W    = 24;
  localparam int NUM_W  = DATA_W + Q_W;
  localparam int CNT_W  = $clog2(Q_W);
  localparam int WSUM_W = Q_W + 4;
  localparam int PROD_W = WSUM_W + 32;

  localparam logic [Q_W-1:0] Q_MAX     = '1;
  // 60000 ms per minute times 256 for the Q16.8 scale
  localparam logic [Q_W-1:0] CAD_SCALE = 24'd15360000;
  // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for any 32-bit x
  localparam logic [31:0]    RECIP_10    = 32'hCCCC_CCCD;
  localparam int             RECIP_SHIFT = 35;

  typedef struct packed {
    logic [DATA_W-1:0] time_ms;
    logic [DATA_W-1:0] step_total;
  } sample_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_SMOOTH,
    ST_RECIP,
    ST_SCALE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/sct_ring_mem.sv
// Sample window memory: one write port, one read port, registered read data.
// Depends on sct_pkg.
`default_nettype none

module sct_ring_mem (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [sct_pkg::SLOT_W-1:0]    waddr,
  input  wire sct_pkg::sample_t              wdata,
  input  wire logic                          re,
  input  wire logic [sct_pkg::SLOT_W-1:0]    raddr,
  output sct_pkg::sample_t                   rdata
);
  import sct_pkg::*;

  sample_t mem [WINDOW_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sct_divider.sv
// Serial restoring divider, one quotient bit per cycle, saturating quotient.
// Depends on sct_pkg.
`default_nettype none

module sct_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [sct_pkg::NUM_W-1:0]     num,
  input  wire logic [sct_pkg::DATA_W-1:0]    den,
  output logic                               done,
  output logic [sct_pkg::Q_W-1:0]            quot
);
  import sct_pkg::*;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] rem;
  logic [Q_W-1:0]    qsh;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;

  assign trial = {rem, qsh[Q_W-1]};
  assign diff  = trial - {1'b0, den};
  assign quot  = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (num[NUM_W-1:Q_W] >= den) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (cnt == CNT_W'(Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      if (num[NUM_W-1:Q_W] >= den) begin
        qsh <= Q_MAX;
      end else begin
        rem <= num[NUM_W-1:Q_W];
        qsh <= num[Q_W-1:0];
      end
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        qsh <= {qsh[Q_W-2:0], 1'b1};
      end else begin
        rem <= trial[DATA_W-1:0];
        qsh <= {qsh[Q_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/step_cadence_tracker.sv
// Step cadence tracker: windowed cadence in Q16.8 steps/min plus smoothed value.
// Result registered at the output; the serial divider (24 quotient bits, one
// per cycle) sets the long path. A new item is accepted only in idle, after the
// previous result is loaded, so a result waiting on m_tready holds off input.
// Sync active-high reset clears window pointers, fill level and both cadence
// values; window memory undefined until written. Uses sct_ring_mem, sct_divider.
`default_nettype none

module step_cadence_tracker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // step_total[31:0], time_ms[63:32]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // cadence_now[23:0], cadence_smooth[47:24]
  output logic             m_tuser    // rate_updated
);
  import sct_pkg::*;

  state_t state, state_next;

  logic [SLOT_W-1:0] write_slot;
  logic [FILL_W-1:0] fill_level;
  logic [Q_W-1:0]    cadence_reg;
  logic [Q_W-1:0]    smooth_reg;
  logic              updated;

  sample_t           in_sample;
  sample_t           old_sample;
  logic [DATA_W-1:0] ds;
  logic [DATA_W-1:0] dt;
  logic [DATA_W-1:0] dt_c;
  logic [NUM_W-1:0]  num;
  logic [WSUM_W-1:0] wsum;
  logic [PROD_W-1:0] prod;

  logic              acc;
  logic [SLOT_W-1:0] slot_inc;
  logic [FILL_W-1:0] fill_inc;
  logic [SUM_W-1:0]  old_sum;
  logic [SLOT_W-1:0] old_slot;
  logic              div_start;
  logic              div_done;
  logic [Q_W-1:0]    div_quot;
  logic              out_load;

  assign acc  = s_tvalid & s_tready;
  assign dt_c = in_sample.time_ms - old_sample.time_ms;

  always_comb begin
    slot_inc = (write_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : write_slot + 1'b1;
    fill_inc = (fill_level == FILL_W'(WINDOW_DEPTH)) ? fill_level : fill_level + 1'b1;
    old_sum  = SUM_W'(slot_inc) + SUM_W'(WINDOW_DEPTH) - SUM_W'(fill_inc);
    if (old_sum >= SUM_W'(WINDOW_DEPTH)) begin
      old_slot = SLOT_W'(old_sum - SUM_W'(WINDOW_DEPTH));
    end else begin
      old_slot = SLOT_W'(old_sum);
    end
  end

  sct_ring_mem u_mem (
    .clk   (clk),
    .we    (acc),
    .waddr (write_slot),
    .wdata (s_tdata),
    .re    (acc),
    .raddr (old_slot),
    .rdata (old_sample)
  );

  sct_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (dt),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        if (fill_level < FILL_W'(2) || dt_c == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_START;
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_SMOOTH;
        end
      end
      ST_SMOOTH: begin
        if (smooth_reg == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_RECIP;
        end
      end
      ST_RECIP: state_next = ST_SCALE;
      ST_SCALE: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // window pointers and cadence state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot  <= '0;
      fill_level  <= '0;
      cadence_reg <= '0;
      smooth_reg  <= '0;
      updated     <= 1'b0;
    end else begin
      if (acc) begin
        write_slot <= slot_inc;
        fill_level <= fill_inc;
        updated    <= 1'b0;
      end
      case (state)
        ST_DIFF: begin
          if (fill_level < FILL_W'(2)) begin
            cadence_reg <= '0;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            cadence_reg <= div_quot;
          end
        end
        ST_SMOOTH: begin
          updated <= 1'b1;
          if (smooth_reg == '0) begin
            smooth_reg <= cadence_reg;
          end
        end
        ST_SCALE: smooth_reg <= prod[RECIP_SHIFT +: Q_W];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (acc) begin
      in_sample <= s_tdata;
    end
    if (state == ST_DIFF) begin
      dt <= dt_c;
      ds <= in_sample.step_total - old_sample.step_total;
    end
    if (state == ST_MUL) begin
      num <= NUM_W'(ds) * NUM_W'(CAD_SCALE);
    end
    if (state == ST_SMOOTH) begin
      wsum <= WSUM_W'(smooth_reg) * WSUM_W'(7) + WSUM_W'(cadence_reg) * WSUM_W'(3);
    end
    if (state == ST_RECIP) begin
      prod <= PROD_W'(wsum) * PROD_W'(RECIP_10);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {smooth_reg, cadence_reg};
      m_tuser <= updated;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= FILL_W'(WINDOW_DEPTH))
    else $error("fill level above window depth");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide state");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    acc |=> !s_tready)
    else $error("second transaction accepted while processing");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result overwritten before taken");
`endif

endmodule

`default_nettype wire
